/* hw/rtl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the Jacobi symbol unit.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int OPERAND_BITS = 64;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_MOD_ZERO = 2'd1;
    localparam logic [1:0] ERR_MOD_EVEN = 2'd2;

    localparam logic signed [1:0] SYM_ZERO = 2'sb00;
    localparam logic signed [1:0] SYM_POS  = 2'sb01;
    localparam logic signed [1:0] SYM_NEG  = 2'sb11;

    typedef struct packed {
        logic [63:0] a_value;
        logic [63:0] m_value;
    } t_jsu_in;

    typedef struct packed {
        logic signed [1:0] symbol;
        logic [1:0]        error_code;
    } t_jsu_out;

endpackage

/* hw/rtl/jacobi_symbol_unit_top.sv */
// ----------------------------------------------------------------------------
// jacobi_symbol_unit_top
// Jacobi symbol (a/m) by the binary method: one shared subtractor/compare,
// one shifter, a sign flag and a small sequencer.
//
// channel  direction  handshake                  word
// input    in         i_in_valid / o_in_ready    jsu_pkg::t_jsu_in  (a, m)
// output   out        o_out_valid / i_out_ready  jsu_pkg::t_jsu_out (symbol, error)
//
// One step per cycle while a is nonzero: halve a when it is even, swap a and m
// when a is below m, or else subtract m from a.
// The 64-bit subtract-and-compare sets the cycle time.
// A zero or even modulus clears a, so the word finishes with no steps and symbol 0.
// Reset (synchronous, active low) clears the sequencer and the output valid.
// A finished result waits in the output register; a new word is taken while
// it waits, and the next result holds in the sequencer until the slot frees.
// ----------------------------------------------------------------------------
module jacobi_symbol_unit_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  jsu_pkg::t_jsu_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output jsu_pkg::t_jsu_out o_out_data
);

    localparam int W = jsu_pkg::OPERAND_BITS;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state            r_state;
    logic [W-1:0]      r_a;
    logic [W-1:0]      r_m;
    logic              r_neg;
    logic [1:0]        r_err;
    logic              r_out_valid;
    jsu_pkg::t_jsu_out r_out;

    logic [W-1:0] in_a;
    logic [W-1:0] in_m;
    logic [1:0]   in_err;
    logic [W:0]   diff;
    logic         borrow;
    logic         a_zero;
    logic         out_free;
    logic         load_out;
    logic         flip_halve;
    logic         flip_swap;
    jsu_pkg::t_jsu_out n_out;

    assign in_a = W'(i_in_data.a_value);
    assign in_m = W'(i_in_data.m_value);

    always_comb begin
        if (in_m == '0) begin
            in_err = jsu_pkg::ERR_MOD_ZERO;
        end else if (!in_m[0]) begin
            in_err = jsu_pkg::ERR_MOD_EVEN;
        end else begin
            in_err = jsu_pkg::ERR_OK;
        end
    end

    assign diff       = {1'b0, r_a} - {1'b0, r_m};
    assign borrow     = diff[W];
    assign a_zero     = (r_a == '0);
    assign out_free   = !r_out_valid || i_out_ready;
    assign load_out   = (r_state == S_RUN) && a_zero && out_free;
    assign flip_halve = (r_m[2:0] == 3'd3) || (r_m[2:0] == 3'd5);
    assign flip_swap  = (r_a[1:0] == 2'd3) && (r_m[1:0] == 2'd3);

    always_comb begin
        n_out.error_code = r_err;
        if (r_err != jsu_pkg::ERR_OK || r_m != W'(1)) begin
            n_out.symbol = jsu_pkg::SYM_ZERO;
        end else if (r_neg) begin
            n_out.symbol = jsu_pkg::SYM_NEG;
        end else begin
            n_out.symbol = jsu_pkg::SYM_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out       <= n_out;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_a     <= (in_err == jsu_pkg::ERR_OK) ? in_a : '0;
                        r_m     <= in_m;
                        r_neg   <= 1'b0;
                        r_err   <= in_err;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (a_zero) begin
                        // hold here until the output slot is free
                        if (out_free) begin
                            r_state <= S_IDLE;
                        end
                    end else if (!r_a[0]) begin
                        r_a   <= r_a >> 1;
                        r_neg <= r_neg ^ flip_halve;
                    end else if (borrow) begin
                        r_a   <= r_m;
                        r_m   <= r_a;
                        r_neg <= r_neg ^ flip_swap;
                    end else begin
                        r_a <= diff[W-1:0];
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* hw/rtl/jsu_checker.sv */
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the Jacobi symbol unit, bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input jsu_pkg::t_jsu_out o_out_data
);

    // an accepted word leaves the unit busy right after the accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after accept");

    // a result appears only when a word has been in work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without work");

    // an error result carries symbol zero
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.error_code != jsu_pkg::ERR_OK)
            |-> (o_out_data.symbol == jsu_pkg::SYM_ZERO))
        else $error("error result with nonzero symbol");

    a_symbol_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.symbol != 2'sb10))
        else $error("illegal symbol code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output dropped or changed while stalled");

endmodule

bind jacobi_symbol_unit_top jsu_checker u_jsu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

/* verif/jacobi_symbol_unit_checker.sv */
// ----------------------------------------------------------------------------
// jacobi_symbol_unit_checker
// Watches both channels of the Jacobi symbol unit. For every accepted input
// word it computes the expected symbol and error code and queues them. Each
// accepted output word is checked field by field against the oldest queued
// entry. The number of words still due and the mismatch count go to the
// testbench top.
// ----------------------------------------------------------------------------
module jacobi_symbol_unit_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  jsu_pkg::t_jsu_in  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  jsu_pkg::t_jsu_out i_out_data,
    output int                o_words_due,
    output int                o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    jsu_pkg::t_jsu_out symbols_due[$];
    int                mismatch_total = 0;

    function automatic jsu_pkg::t_jsu_out jacobi_of(logic [63:0] a_in, logic [63:0] m_in);
        logic [63:0]       mask;
        logic [63:0]       a;
        logic [63:0]       m;
        logic [63:0]       t;
        int                sign;
        jsu_pkg::t_jsu_out r;
        mask = (jsu_pkg::OPERAND_BITS >= 64) ? '1
                                             : ((64'd1 << jsu_pkg::OPERAND_BITS) - 64'd1);
        a = a_in & mask;
        m = m_in & mask;
        r.symbol     = jsu_pkg::SYM_ZERO;
        r.error_code = jsu_pkg::ERR_OK;
        if (m == 64'd0) begin
            r.error_code = jsu_pkg::ERR_MOD_ZERO;
        end else if (!m[0]) begin
            r.error_code = jsu_pkg::ERR_MOD_EVEN;
        end else begin
            sign = 1;
            a = a % m;
            while (a != 64'd0) begin
                // (2/m) is -1 exactly when m is 3 or 5 mod 8
                while (!a[0]) begin
                    a = a >> 1;
                    if (m[2:0] == 3'd3 || m[2:0] == 3'd5)
                        sign = -sign;
                end
                t = a;
                a = m;
                m = t;
                if (a[1:0] == 2'd3 && m[1:0] == 2'd3)
                    sign = -sign;
                a = a % m;
            end
            // a shared factor leaves m above one
            if (m == 64'd1)
                r.symbol = (sign < 0) ? jsu_pkg::SYM_NEG : jsu_pkg::SYM_POS;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        jsu_pkg::t_jsu_out want;
        if (i_rst_n) begin
            // retire before queueing so a same-edge input never pairs with its own result
            if (i_out_valid && i_out_ready) begin
                if (symbols_due.size() == 0) begin
                    $error("output word with no input pending: symbol %0d error_code %0d",
                           $signed(i_out_data.symbol), i_out_data.error_code);
                    mismatch_total++;
                end else begin
                    want = symbols_due.pop_front();
                    if (i_out_data.symbol !== want.symbol) begin
                        $error("symbol: expected %0d, actual %0d",
                               $signed(want.symbol), $signed(i_out_data.symbol));
                        mismatch_total++;
                    end
                    if (i_out_data.error_code !== want.error_code) begin
                        $error("error_code: expected %0d, actual %0d",
                               want.error_code, i_out_data.error_code);
                        mismatch_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                symbols_due.push_back(jacobi_of(i_in_data.a_value, i_in_data.m_value));
        end
        o_words_due  <= symbols_due.size();
        o_mismatches <= mismatch_total;
    end

endmodule

/* verif/jacobi_symbol_unit_top_tb.sv */
// ----------------------------------------------------------------------------
// jacobi_symbol_unit_top_tb
// Drives the Jacobi symbol unit with a directed set of corner operands and
// then random words: mostly odd moduli of random size, some with a planted
// common factor, some tiny, some even or zero. Both channels idle at random,
// with stretches of back-to-back traffic. The checker does the comparing.
// ----------------------------------------------------------------------------
module jacobi_symbol_unit_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1300;
    localparam int MAX_GAP      = 14;
    localparam int DRAIN_CYCLES = 3 * jsu_pkg::OPERAND_BITS + 16;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    jsu_pkg::t_jsu_in  i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    jsu_pkg::t_jsu_out o_out_data;

    int   words_due;
    int   mismatches;
    logic back_to_back = 1'b0;

    always #5 i_clk = ~i_clk;

    jacobi_symbol_unit_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    jacobi_symbol_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_words_due  (words_due),
        .o_mismatches (mismatches)
    );

    function automatic logic [63:0] rand_bits(int nbits);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (nbits < 64)
            v = v & ((64'd1 << nbits) - 64'd1);
        return v;
    endfunction

    function automatic int draw_wait();
        return back_to_back ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic int draw_width();
        return ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 64);
    endfunction

    task automatic send_word(input logic [63:0] a, input logic [63:0] m);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{a_value: a, m_value: m};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (words_due != 0);
    endtask

    task automatic send_random_word();
        logic [63:0] a;
        logic [63:0] m;
        logic [63:0] f;
        int          kind;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            m = rand_bits(draw_width()) | 64'd1;
            a = rand_bits(draw_width());
        end else if (kind < 82) begin
            // plant a shared odd factor; sizes keep the products from wrapping
            f = rand_bits($urandom_range(2, 8)) | 64'd1;
            if (f == 64'd1)
                f = 64'd3;
            m = f * (rand_bits($urandom_range(1, 32)) | 64'd1);
            a = f * rand_bits($urandom_range(1, 40));
        end else if (kind < 88) begin
            m = rand_bits($urandom_range(1, 4)) | 64'd1;
            a = rand_bits(draw_width());
        end else if (kind < 95) begin
            m = rand_bits(draw_width()) & ~64'd1;
            a = rand_bits(draw_width());
        end else begin
            m = 64'd0;
            a = rand_bits(draw_width());
        end
        send_word(a, m);
    endtask

    initial begin
        #20ms;
        $display("jacobi_symbol_unit_top: mismatch");
        $finish;
    end

    // result side: hold off each word for a random stall once it shows up
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                do @(posedge i_clk); while (!o_out_valid);
                repeat (stall - 1) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners: modulus one, zero, even, extremes, shared factors, known signs
        send_word(64'd0, 64'd1);
        send_word('1, 64'd1);
        send_word(64'd0, 64'd0);
        send_word('1, 64'd0);
        send_word(64'd3, 64'd2);
        send_word('1, 64'hFFFF_FFFF_FFFF_FFFE);
        send_word(64'd5, 64'h8000_0000_0000_0000);
        send_word('1, '1);
        send_word(64'hFFFF_FFFF_FFFF_FFFE, '1);
        send_word(64'd0, '1);
        send_word(64'd9, 64'd15);
        send_word(64'd2, 64'd3);
        send_word(64'd2, 64'd7);
        send_word(64'd3, 64'd7);
        send_word(64'd1, 64'hFFFF_FFFF_FFFF_FFC5);
        send_word(64'd2, 64'hFFFF_FFFF_FFFF_FFC5);
        send_word('1, 64'hFFFF_FFFF_FFFF_FFC5);
        send_word(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFC5);
        send_word('1, 64'd3);
        send_word(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
        send_word(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB);
        send_word(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3211);
        wait_drained();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // every fourth block of words runs without idling
            if (n % 150 == 0)
                back_to_back = ((n / 150) % 4 == 3);
            if (n == RANDOM_WORDS / 2)
                wait_drained();
            send_random_word();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("jacobi_symbol_unit_top: match");
        end else begin
            $display("jacobi_symbol_unit_top: mismatch");
        end
        $finish;
    end

endmodule

/* jacobi_symbol_unit_top.f */
hw/rtl/jsu_pkg.sv
hw/rtl/jacobi_symbol_unit_top.sv
hw/rtl/jsu_checker.sv
verif/jacobi_symbol_unit_checker.sv
verif/jacobi_symbol_unit_top_tb.sv
